FILE: rtl/drss_pkg.sv
`timescale 1ns / 1ps
package drss_pkg;

    localparam int COUNTER_BITS = 12;
    localparam int CFG_ADDR_W   = 5;
    localparam int CFG_DATA_W   = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    // register indexes
    localparam logic [2:0] REG_HOLD_TICKS = 3'd0;
    localparam logic [2:0] REG_RAMP_TICKS = 3'd1;
    localparam logic [2:0] REG_HOLD_LEVEL = 3'd2;
    localparam logic [2:0] REG_UP_STEP    = 3'd3;
    localparam logic [2:0] REG_DOWN_STEP  = 3'd4;

    localparam logic [11:0] HOLD_TICKS_RST = 12'd1000;
    localparam logic [11:0] RAMP_TICKS_RST = 12'd1000;
    localparam logic [15:0] HOLD_LEVEL_RST = 16'd286;
    localparam logic [7:0]  UP_STEP_RST    = 8'd2;
    localparam logic [7:0]  DOWN_STEP_RST  = 8'd20;

    // request operations
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_DAC_A  = 2'd0;
    localparam logic [1:0] KIND_DAC_B  = 2'd1;
    localparam logic [1:0] KIND_SERIAL = 2'd2;
    localparam logic [1:0] KIND_RELAY  = 2'd3;

    // work handed from front to back
    localparam logic [2:0] JOB_OFF      = 3'd0;
    localparam logic [2:0] JOB_DAC      = 3'd1;
    localparam logic [2:0] JOB_RAMP     = 3'd2;
    localparam logic [2:0] JOB_RAMP_END = 3'd3;
    localparam logic [2:0] JOB_PACKAGE  = 3'd4;
    localparam logic [2:0] JOB_RELAY    = 3'd5;

    localparam logic [15:0] PARK_CODE  = 16'h07f0;
    localparam logic [15:0] RELAY_IDLE = 16'hffff;

    typedef logic [11:0] t_sample;

    typedef struct packed {
        logic [11:0] hold_ticks;
        logic [11:0] ramp_ticks;
        logic [15:0] hold_level;
        logic [7:0]  up_step;
        logic [7:0]  down_step;
    } t_cfg;

    typedef struct packed {
        logic [2:0]        job;
        logic              extra;
        logic [15:0]       value;
        t_sample [3:0]     sample;
    } t_job;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] dac_code;
        logic [7:0]  serial_byte;
        logic [15:0] relay_pattern;
        logic        last;
    } t_result;

endpackage

FILE: rtl/dac_ramp_scan_sequencer.sv
`timescale 1ns / 1ps
// DAC ramp scan sequencer. A request (timer tick or serial command byte) is
// accepted in any cycle in which full is low: the front decodes it against the
// scan state in that same cycle and drops a compact job into a four-entry queue.
// The back expands each job into its results at one result per clock unless
// the result port stalls; most requests give one or two results, a ramp tick
// that samples channels 3 and 4 gives five, and the end of the ramp gives nine.
// That expansion is what sets the sustained rate; full rises once four jobs
// wait, whether behind a stalled result port or behind jobs with several
// results. A phase-zero tick that ends the hold gives no result at all.
// Configuration registers sit at byte addresses 4*i and may only be written
// while no request is in flight.
module dac_ramp_scan_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            i_operation,
    input  logic [7:0]                      i_command_byte,
    input  logic [11:0]                     i_sample_ch1,
    input  logic [11:0]                     i_sample_ch2,
    input  logic [11:0]                     i_sample_ch3,
    input  logic [11:0]                     i_sample_ch4,
    input  logic [11:0]                     i_sample_ch5,
    input  logic [11:0]                     i_sample_ch6,
    output logic                            empty,
    input  logic                            pop,
    output logic [1:0]                      o_kind,
    output logic [15:0]                     o_dac_code,
    output logic [7:0]                      o_serial_byte,
    output logic [15:0]                     o_relay_pattern,
    output logic                            o_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [drss_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [drss_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [drss_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import drss_pkg::*;

    t_cfg            r_cfg;
    logic            cfg_write;
    logic [2:0]      reg_index;
    logic            accept;
    logic            q_full;
    logic            q_push;
    logic            f_job_valid;
    t_job            f_job;
    logic            q_valid;
    t_job            q_job;
    logic            q_pop;
    logic            res_valid;
    t_result         res;
    t_sample [5:0]   samples;

    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hold_ticks <= HOLD_TICKS_RST;
            r_cfg.ramp_ticks <= RAMP_TICKS_RST;
            r_cfg.hold_level <= HOLD_LEVEL_RST;
            r_cfg.up_step    <= UP_STEP_RST;
            r_cfg.down_step  <= DOWN_STEP_RST;
        end else if (cfg_write) begin
            case (reg_index)
                REG_HOLD_TICKS: r_cfg.hold_ticks <= pwdata[11:0];
                REG_RAMP_TICKS: r_cfg.ramp_ticks <= pwdata[11:0];
                REG_HOLD_LEVEL: r_cfg.hold_level <= pwdata[15:0];
                REG_UP_STEP:    r_cfg.up_step    <= pwdata[7:0];
                REG_DOWN_STEP:  r_cfg.down_step  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_index)
            REG_HOLD_TICKS: prdata = CFG_DATA_W'(r_cfg.hold_ticks);
            REG_RAMP_TICKS: prdata = CFG_DATA_W'(r_cfg.ramp_ticks);
            REG_HOLD_LEVEL: prdata = CFG_DATA_W'(r_cfg.hold_level);
            REG_UP_STEP:    prdata = CFG_DATA_W'(r_cfg.up_step);
            REG_DOWN_STEP:  prdata = CFG_DATA_W'(r_cfg.down_step);
            default:        prdata = '0;
        endcase
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    assign samples[0] = i_sample_ch1;
    assign samples[1] = i_sample_ch2;
    assign samples[2] = i_sample_ch3;
    assign samples[3] = i_sample_ch4;
    assign samples[4] = i_sample_ch5;
    assign samples[5] = i_sample_ch6;

    drss_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_operation    (i_operation),
        .i_command_byte (i_command_byte),
        .i_samples      (samples),
        .o_job_valid    (f_job_valid),
        .o_job          (f_job)
    );

    assign q_push = accept && f_job_valid;

    drss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (q_pop)
    );

    drss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    assign empty           = !res_valid;
    assign o_kind          = res.kind;
    assign o_dac_code      = res.dac_code;
    assign o_serial_byte   = res.serial_byte;
    assign o_relay_pattern = res.relay_pattern;
    assign o_last          = res.last;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into full queue");
    a_pop_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("job retired from empty queue");
    a_serial_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != KIND_SERIAL) |-> o_serial_byte == 8'd0)
        else $error("serial byte set on non-serial result");
`endif

endmodule

FILE: rtl/drss_front.sv
`timescale 1ns / 1ps
module drss_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  drss_pkg::t_cfg          i_cfg,
    input  logic                    i_accept,
    input  logic                    i_operation,
    input  logic [7:0]              i_command_byte,
    input  drss_pkg::t_sample [5:0] i_samples,
    output logic                    o_job_valid,
    output drss_pkg::t_job          o_job
);
    import drss_pkg::*;

    localparam int CMP_W = 16;
    localparam logic [1:0] PH_HOLD      = 2'd0;
    localparam logic [1:0] PH_RAMP_UP   = 2'd1;
    localparam logic [1:0] PH_RAMP_DOWN = 2'd2;
    localparam logic [1:0] PH_REPORT    = 2'd3;

    localparam logic [7:0] CMD_SCAN_OFF = 8'h00;
    localparam logic [7:0] CMD_SCAN_ON  = 8'h01;
    localparam logic [7:0] CMD_GRP1_LO  = 8'h10;
    localparam logic [7:0] CMD_GRP1_HI  = 8'h17;
    localparam logic [7:0] CMD_GRP2_LO  = 8'h20;
    localparam logic [7:0] CMD_GRP2_HI  = 8'h25;

    localparam logic [7:0] FINE_WRAP    = 8'hfa;
    localparam logic [7:0] FINE_TOP     = 8'hf0;
    localparam logic [7:0] PARK_COARSE  = 8'h07;
    localparam logic [7:0] COARSE_LIMIT = 8'h0f;
    localparam logic [3:0] SAMPLE_SLOT  = 4'd5;
    localparam logic [3:0] MOD_LAST     = 4'd9;
    localparam int         RAMP_RESTART = 100;

    localparam logic [COUNTER_BITS-1:0] CNT_ONE  = COUNTER_BITS'(1);
    localparam logic [COUNTER_BITS-1:0] CNT_MAX  = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CNT_BACK = COUNTER_BITS'(RAMP_RESTART + 1);
    localparam logic [3:0]              MOD_BACK = 4'((RAMP_RESTART + 1) % 10);

    logic                    r_scan_on, n_scan_on;
    logic [1:0]              r_phase, n_phase;
    logic [COUNTER_BITS-1:0] r_hold_count, n_hold_count;
    logic [COUNTER_BITS-1:0] r_ramp_count, n_ramp_count;
    logic [3:0]              r_ramp_mod, n_ramp_mod;   // ramp_count mod 10
    logic [7:0]              r_fine, n_fine;
    logic [7:0]              r_coarse, n_coarse;
    logic [7:0]              r_package, n_package;

    logic [3:0] ramp_mod_inc;
    logic [2:0] grp1_sel;
    logic [2:0] grp2_sel;

    assign grp1_sel = i_command_byte[2:0];
    assign grp2_sel = i_command_byte[2:0];

    // ramp_count wraps at the counter width, which resets the mod tracking
    always_comb begin
        if (r_ramp_count == CNT_MAX || r_ramp_mod == MOD_LAST) begin
            ramp_mod_inc = 4'd0;
        end else begin
            ramp_mod_inc = r_ramp_mod + 4'd1;
        end
    end

    always_comb begin
        n_scan_on    = r_scan_on;
        n_phase      = r_phase;
        n_hold_count = r_hold_count;
        n_ramp_count = r_ramp_count;
        n_ramp_mod   = r_ramp_mod;
        n_fine       = r_fine;
        n_coarse     = r_coarse;
        n_package    = r_package;
        o_job_valid  = 1'b0;
        o_job        = '0;

        if (i_operation == OP_COMMAND) begin
            o_job_valid = 1'b1;
            o_job.job   = JOB_RELAY;
            if (i_command_byte == CMD_SCAN_ON) begin
                n_scan_on = 1'b1;
                n_fine    = 8'd0;
                n_coarse  = 8'd0;
            end else if (i_command_byte == CMD_SCAN_OFF) begin
                n_scan_on = 1'b0;
                n_package = 8'd0;
                n_fine    = 8'd0;
                n_coarse  = 8'd0;
            end else if (i_command_byte inside {[CMD_GRP1_LO:CMD_GRP1_HI]}) begin
                o_job.extra = 1'b1;
                o_job.value = ~(16'h8000 >> grp1_sel);
            end else if (i_command_byte inside {[CMD_GRP2_LO:CMD_GRP2_HI]}) begin
                o_job.extra = 1'b1;
                o_job.value = ~(16'h0020 >> grp2_sel);
            end
        end else if (!r_scan_on) begin
            n_fine       = 8'd0;
            n_coarse     = 8'd0;
            n_ramp_count = '0;
            n_ramp_mod   = 4'd0;
            n_phase      = PH_HOLD;
            o_job_valid  = 1'b1;
            o_job.job    = JOB_OFF;
        end else begin
            case (r_phase)
                PH_HOLD: begin
                    if (CMP_W'(r_hold_count) < CMP_W'(i_cfg.hold_ticks)) begin
                        n_hold_count = r_hold_count + CNT_ONE;
                        o_job_valid  = 1'b1;
                        o_job.job    = JOB_DAC;
                        o_job.value  = i_cfg.hold_level;
                    end else begin
                        n_hold_count = '0;
                        n_phase      = PH_RAMP_UP;
                    end
                end
                PH_RAMP_UP: begin
                    o_job_valid = 1'b1;
                    if (CMP_W'(r_ramp_count) < CMP_W'(i_cfg.ramp_ticks)) begin
                        o_job.job       = JOB_RAMP;
                        o_job.value     = {r_coarse, r_fine};
                        o_job.extra     = (r_ramp_mod == SAMPLE_SLOT);
                        o_job.sample[0] = i_samples[2];
                        o_job.sample[1] = i_samples[3];
                        if (r_fine != FINE_WRAP) begin
                            n_fine = r_fine + i_cfg.up_step;
                        end else begin
                            n_fine   = 8'd0;
                            n_coarse = r_coarse + 8'd1;
                        end
                        n_ramp_count = r_ramp_count + CNT_ONE;
                        n_ramp_mod   = ramp_mod_inc;
                    end else begin
                        o_job.job       = JOB_RAMP_END;
                        o_job.sample[0] = i_samples[0];
                        o_job.sample[1] = i_samples[1];
                        o_job.sample[2] = i_samples[4];
                        o_job.sample[3] = i_samples[5];
                        n_fine          = FINE_TOP;
                        n_coarse        = PARK_COARSE;
                        n_ramp_count    = CNT_BACK;
                        n_ramp_mod      = MOD_BACK;
                        n_phase         = PH_RAMP_DOWN;
                    end
                end
                PH_RAMP_DOWN: begin
                    o_job_valid = 1'b1;
                    o_job.job   = JOB_DAC;
                    if (r_ramp_count != '0 && r_coarse <= COARSE_LIMIT) begin
                        o_job.value = {r_coarse, r_fine};
                        if (r_fine != 8'd0) begin
                            n_fine = r_fine - i_cfg.down_step;
                        end else begin
                            n_fine   = FINE_TOP;
                            n_coarse = r_coarse - 8'd1;
                        end
                    end else begin
                        n_ramp_count = '0;
                        n_ramp_mod   = 4'd0;
                        n_fine       = 8'd0;
                        n_coarse     = 8'd0;
                        n_phase      = PH_REPORT;
                    end
                end
                default: begin
                    n_package    = r_package + 8'd1;
                    o_job_valid  = 1'b1;
                    o_job.job    = JOB_PACKAGE;
                    o_job.value  = {8'd0, n_package};
                    n_phase      = PH_HOLD;
                    n_ramp_count = '0;
                    n_ramp_mod   = 4'd0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on    <= 1'b0;
            r_phase      <= PH_HOLD;
            r_hold_count <= '0;
            r_ramp_count <= '0;
            r_ramp_mod   <= 4'd0;
            r_fine       <= 8'd0;
            r_coarse     <= 8'd0;
            r_package    <= 8'd0;
        end else if (i_accept) begin
            r_scan_on    <= n_scan_on;
            r_phase      <= n_phase;
            r_hold_count <= n_hold_count;
            r_ramp_count <= n_ramp_count;
            r_ramp_mod   <= n_ramp_mod;
            r_fine       <= n_fine;
            r_coarse     <= n_coarse;
            r_package    <= n_package;
        end
    end

endmodule

FILE: rtl/drss_queue.sv
`timescale 1ns / 1ps
module drss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  drss_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output drss_pkg::t_job o_job,
    input  logic           i_pop
);
    import drss_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/drss_back.sv
`timescale 1ns / 1ps
module drss_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  drss_pkg::t_job    i_job,
    output logic              o_job_pop,
    output logic              o_res_valid,
    output drss_pkg::t_result o_res,
    input  logic              i_res_pop
);
    import drss_pkg::*;

    logic [3:0] r_idx;
    logic       r_valid;
    t_result    r_res;
    t_result    res;
    logic [3:0] res_count;
    logic [3:0] k;
    logic       load;

    function automatic logic [7:0] sample_byte(input t_sample s, input logic high);
        if (high) begin
            return s[11:4];
        end
        return {4'd0, s[3:0]};
    endfunction

    assign k = r_idx - 4'd1;

    always_comb begin
        case (i_job.job)
            JOB_OFF:      res_count = 4'd2;
            JOB_RAMP:     res_count = i_job.extra ? 4'd5 : 4'd1;
            JOB_RAMP_END: res_count = 4'd9;
            JOB_RELAY:    res_count = i_job.extra ? 4'd2 : 4'd1;
            default:      res_count = 4'd1;
        endcase
    end

    always_comb begin
        res      = '0;
        res.last = (r_idx == res_count - 4'd1);
        case (i_job.job)
            JOB_OFF: begin
                res.kind = (r_idx == 4'd0) ? KIND_DAC_A : KIND_DAC_B;
            end
            JOB_DAC: begin
                res.kind     = KIND_DAC_A;
                res.dac_code = i_job.value;
            end
            JOB_RAMP: begin
                if (r_idx == 4'd0) begin
                    res.kind     = KIND_DAC_A;
                    res.dac_code = i_job.value;
                end else begin
                    res.kind        = KIND_SERIAL;
                    res.serial_byte = sample_byte(i_job.sample[{1'b0, k[1]}], k[0]);
                end
            end
            JOB_RAMP_END: begin
                if (r_idx[3]) begin
                    res.kind     = KIND_DAC_A;
                    res.dac_code = PARK_CODE;
                end else begin
                    res.kind        = KIND_SERIAL;
                    res.serial_byte = sample_byte(i_job.sample[r_idx[2:1]], r_idx[0]);
                end
            end
            JOB_PACKAGE: begin
                res.kind        = KIND_SERIAL;
                res.serial_byte = i_job.value[7:0];
            end
            JOB_RELAY: begin
                res.kind = KIND_RELAY;
                res.relay_pattern = (i_job.extra && r_idx == 4'd0) ? i_job.value : RELAY_IDLE;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    // output register frees up in the same cycle it is taken
    assign load        = i_job_valid && (!r_valid || i_res_pop);
    assign o_job_pop   = load && res.last;
    assign o_res_valid = r_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= res.last ? 4'd0 : r_idx + 4'd1;
            end else if (i_res_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= res;
        end
    end

endmodule
